// File: hdl/bpcs_pkg.sv
`timescale 1ns / 1ps
package bpcs_pkg;

   localparam int MAX_OBJECTS_DEF = 64;

   // configuration register indexes
   localparam logic REG_MIN_PEOPLE = 1'b0;
   localparam logic REG_MAX_DIST   = 1'b1;

   localparam logic [6:0]  MIN_PEOPLE_RST = 7'd2;
   localparam logic [15:0] MAX_DIST_RST   = 16'd1600;

   // one stored box
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } obj_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SEED_CHK,
      S_POP,
      S_UREAD,
      S_UBOX,
      S_SCAN,
      S_DRAIN,
      S_AREA,
      S_PICK,
      S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic frame_start;
      logic seed_next;
      logic seed_open;
      logic pop;
      logic ubox;
      logic issue;
      logic area;
      logic pick;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic seed_done;
      logic seed_visited;
      logic stack_empty;
      logic pipe_busy;
      logic scan_last;
      logic out_full;
   } status_type;

endpackage

// File: hdl/bpcs_ctrl.sv
`timescale 1ns / 1ps
module bpcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_object,
   output logic                 req_ready,
   input  bpcs_pkg::status_type status,
   output bpcs_pkg::cmd_type    cmd
);

   bpcs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpcs_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpcs_pkg::S_LOAD: begin
            if (req_valid && req_last_object) state_in = bpcs_pkg::S_SEED_CHK;
         end
         bpcs_pkg::S_SEED_CHK: begin
            if (status.seed_done)          state_in = bpcs_pkg::S_OUT;
            else if (!status.seed_visited) state_in = bpcs_pkg::S_POP;
         end
         bpcs_pkg::S_POP:   state_in = bpcs_pkg::S_UREAD;
         bpcs_pkg::S_UREAD: state_in = bpcs_pkg::S_UBOX;
         bpcs_pkg::S_UBOX:  state_in = bpcs_pkg::S_SCAN;
         bpcs_pkg::S_SCAN: begin
            if (status.scan_last) state_in = bpcs_pkg::S_DRAIN;
         end
         bpcs_pkg::S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = status.stack_empty ? bpcs_pkg::S_AREA : bpcs_pkg::S_POP;
            end
         end
         bpcs_pkg::S_AREA: state_in = bpcs_pkg::S_PICK;
         bpcs_pkg::S_PICK: state_in = bpcs_pkg::S_SEED_CHK;
         bpcs_pkg::S_OUT: begin
            if (!status.out_full) state_in = bpcs_pkg::S_LOAD;
         end
         default: state_in = bpcs_pkg::S_LOAD;
      endcase
   end

   // commands
   always_comb begin
      cmd             = '0;
      req_ready       = (state_ff == bpcs_pkg::S_LOAD);
      cmd.load        = req_ready && req_valid;
      cmd.frame_start = cmd.load && req_last_object;
      cmd.seed_next   = ((state_ff == bpcs_pkg::S_SEED_CHK) && !status.seed_done &&
                         status.seed_visited) || (state_ff == bpcs_pkg::S_PICK);
      cmd.seed_open   = (state_ff == bpcs_pkg::S_SEED_CHK) && !status.seed_done &&
                        !status.seed_visited;
      cmd.pop         = (state_ff == bpcs_pkg::S_POP);
      cmd.ubox        = (state_ff == bpcs_pkg::S_UBOX);
      cmd.issue       = (state_ff == bpcs_pkg::S_SCAN);
      cmd.area        = (state_ff == bpcs_pkg::S_AREA);
      cmd.pick        = (state_ff == bpcs_pkg::S_PICK);
      cmd.emit        = (state_ff == bpcs_pkg::S_OUT) && !status.out_full;
   end

endmodule

// File: hdl/bpcs_dpath.sv
`timescale 1ns / 1ps
module bpcs_dpath #(
   parameter int MAX_OBJECTS = bpcs_pkg::MAX_OBJECTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bpcs_pkg::cmd_type    cmd,
   output bpcs_pkg::status_type status,
   input  logic                 csr_we,
   input  logic                 csr_addr,
   input  logic [15:0]          csr_wdata,
   input  logic signed [15:0]   req_pos_x,
   input  logic signed [15:0]   req_pos_y,
   input  logic [14:0]          req_box_width,
   input  logic [14:0]          req_box_height,
   input  logic                 req_visible,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic signed [15:0]   rsp_group_x,
   output logic signed [15:0]   rsp_group_y,
   output logic [16:0]          rsp_group_width,
   output logic [16:0]          rsp_group_height,
   output logic [6:0]           rsp_member_count
);

   localparam int IDX_W = $clog2(MAX_OBJECTS);
   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   // configuration
   logic [6:0]  min_people_ff;
   logic [15:0] max_dist_ff;
   logic [33:0] lim_ff;
   logic [31:0] md_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_people_ff <= bpcs_pkg::MIN_PEOPLE_RST;
         max_dist_ff   <= bpcs_pkg::MAX_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpcs_pkg::REG_MIN_PEOPLE: min_people_ff <= csr_wdata[6:0];
            bpcs_pkg::REG_MAX_DIST:   max_dist_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // link limit on doubled centres: 4 * max_dist^2
   assign md_sq = max_dist_ff * max_dist_ff;
   always_ff @(posedge clock) lim_ff <= {md_sq, 2'b00};

   // box store, one write port, two registered read ports
   bpcs_pkg::obj_type store_mem [MAX_OBJECTS];
   bpcs_pkg::obj_type rd_a_ff, rd_b_ff, wr_obj;
   logic [CNT_W-1:0]  n_ff;
   logic [IDX_W-1:0]  stk_rd_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic              store_we;

   assign wr_obj   = '{x: req_pos_x, y: req_pos_y, w: req_box_width, h: req_box_height};
   assign store_we = cmd.load && req_visible && (n_ff < CNT_W'(MAX_OBJECTS));

   always_ff @(posedge clock) begin
      if (store_we) store_mem[n_ff[IDX_W-1:0]] <= wr_obj;
      rd_a_ff <= store_mem[stk_rd_ff];
      rd_b_ff <= store_mem[scan_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) n_ff <= '0;
      else if (store_we)     n_ff <= n_ff + CNT_W'(1);
   end

   // walk stack and visited marks
   logic [IDX_W-1:0]       stack_mem [MAX_OBJECTS];
   logic [CNT_W-1:0]       sp_ff, seed_ff;
   logic [MAX_OBJECTS-1:0] visited_ff;
   logic                   push;
   logic [IDX_W-1:0]       idx2_ff;
   logic [IDX_W-1:0]       stk_wr_idx;
   logic [CNT_W-1:0]       sp_dec;

   assign sp_dec     = sp_ff - CNT_W'(1);
   assign stk_wr_idx = cmd.seed_open ? seed_ff[IDX_W-1:0] : idx2_ff;

   always_ff @(posedge clock) begin
      if (cmd.seed_open || push) stack_mem[sp_ff[IDX_W-1:0]] <= stk_wr_idx;
      if (cmd.pop) stk_rd_ff <= stack_mem[sp_dec[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         visited_ff <= '0;
         seed_ff    <= '0;
      end else begin
         if (cmd.frame_start) begin
            visited_ff <= '0;
            seed_ff    <= '0;
         end else begin
            if (cmd.seed_open) visited_ff[seed_ff[IDX_W-1:0]] <= 1'b1;
            if (push)          visited_ff[idx2_ff] <= 1'b1;
            if (cmd.seed_next) seed_ff <= seed_ff + CNT_W'(1);
         end
         if (cmd.seed_open || push) sp_ff <= sp_ff + CNT_W'(1);
         else if (cmd.pop)          sp_ff <= sp_dec;
      end
   end

   // cluster accumulator: merge of popped member
   logic signed [15:0] cl_x_ff, cl_y_ff;
   logic [16:0]        cl_w_ff, cl_h_ff;
   logic [CNT_W-1:0]   cl_cnt_ff;
   logic signed [17:0] cu_x_ff, cu_y_ff;
   logic               a_empty, b_empty;
   logic signed [15:0] x0, y0;
   logic signed [17:0] ax1, bx1, ay1, by1, x1, y1;

   always_comb begin
      a_empty = (cl_w_ff == '0) || (cl_h_ff == '0);
      b_empty = (rd_a_ff.w == '0) || (rd_a_ff.h == '0);
      x0  = (cl_x_ff < rd_a_ff.x) ? cl_x_ff : rd_a_ff.x;
      y0  = (cl_y_ff < rd_a_ff.y) ? cl_y_ff : rd_a_ff.y;
      ax1 = $signed({{2{cl_x_ff[15]}}, cl_x_ff}) + $signed({1'b0, cl_w_ff});
      ay1 = $signed({{2{cl_y_ff[15]}}, cl_y_ff}) + $signed({1'b0, cl_h_ff});
      bx1 = $signed({{2{rd_a_ff.x[15]}}, rd_a_ff.x}) + $signed({3'b000, rd_a_ff.w});
      by1 = $signed({{2{rd_a_ff.y[15]}}, rd_a_ff.y}) + $signed({3'b000, rd_a_ff.h});
      x1  = (ax1 > bx1) ? ax1 : bx1;
      y1  = (ay1 > by1) ? ay1 : by1;
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_open) cl_cnt_ff <= '0;
      if (cmd.ubox) begin
         cl_cnt_ff <= cl_cnt_ff + CNT_W'(1);
         // doubled centre of the member being expanded
         cu_x_ff <= $signed({rd_a_ff.x[15], rd_a_ff.x, 1'b0}) +
                    $signed({3'b000, rd_a_ff.w});
         cu_y_ff <= $signed({rd_a_ff.y[15], rd_a_ff.y, 1'b0}) +
                    $signed({3'b000, rd_a_ff.h});
         if ((cl_cnt_ff == '0) || a_empty) begin
            cl_x_ff <= rd_a_ff.x;
            cl_y_ff <= rd_a_ff.y;
            cl_w_ff <= {2'b00, rd_a_ff.w};
            cl_h_ff <= {2'b00, rd_a_ff.h};
         end else if (!b_empty) begin
            cl_x_ff <= x0;
            cl_y_ff <= y0;
            cl_w_ff <= 17'(x1 - $signed({{2{x0[15]}}, x0}));
            cl_h_ff <= 17'(y1 - $signed({{2{y0[15]}}, y0}));
         end
      end
   end

   // link test pipeline over scan index
   logic               vld0_ff, vld1_ff, vld2_ff;
   logic [IDX_W-1:0]   idx0_ff, idx1_ff;
   logic signed [17:0] cb_x, cb_y;
   logic signed [18:0] dx_ff, dy_ff;
   logic signed [37:0] px, py;
   logic [35:0]        sqx_ff, sqy_ff;
   logic [36:0]        d2;

   assign cb_x = $signed({rd_b_ff.x[15], rd_b_ff.x, 1'b0}) + $signed({3'b000, rd_b_ff.w});
   assign cb_y = $signed({rd_b_ff.y[15], rd_b_ff.y, 1'b0}) + $signed({3'b000, rd_b_ff.h});
   assign px   = dx_ff * dx_ff;
   assign py   = dy_ff * dy_ff;
   assign d2   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign push = vld2_ff && !visited_ff[idx2_ff] && (d2 < {3'b000, lim_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld0_ff <= cmd.issue;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ubox)       scan_ff <= '0;
      else if (cmd.issue) scan_ff <= scan_ff + CNT_W'(1);
      idx0_ff <= scan_ff[IDX_W-1:0];
      idx1_ff <= idx0_ff;
      idx2_ff <= idx1_ff;
      dx_ff   <= $signed({cu_x_ff[17], cu_x_ff}) - $signed({cb_x[17], cb_x});
      dy_ff   <= $signed({cu_y_ff[17], cu_y_ff}) - $signed({cb_y[17], cb_y});
      sqx_ff  <= px[35:0];
      sqy_ff  <= py[35:0];
   end

   // cluster scoring
   logic [33:0]        area_ff, best_area_ff;
   logic               found_ff;
   logic signed [15:0] best_x_ff, best_y_ff;
   logic [16:0]        best_w_ff, best_h_ff;
   logic [CNT_W-1:0]   best_cnt_ff;
   logic [6:0]         need;
   logic [CMP_W-1:0]   cnt_ext, best_ext, need_ext;
   logic               take;

   assign need     = (min_people_ff == '0) ? 7'd1 : min_people_ff;
   assign cnt_ext  = CMP_W'(cl_cnt_ff);
   assign best_ext = CMP_W'(best_cnt_ff);
   assign need_ext = CMP_W'(need);
   assign take     = (cnt_ext >= need_ext) &&
                     (!found_ff || (cnt_ext > best_ext) ||
                      ((cnt_ext == best_ext) && (area_ff > best_area_ff)));

   always_ff @(posedge clock) begin
      if (cmd.area) area_ff <= cl_w_ff * cl_h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.frame_start) begin
         found_ff <= 1'b0;
      end else if (cmd.pick && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.frame_start) begin
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_w_ff    <= '0;
         best_h_ff    <= '0;
         best_cnt_ff  <= '0;
         best_area_ff <= '0;
      end else if (cmd.pick && take) begin
         best_x_ff    <= cl_x_ff;
         best_y_ff    <= cl_y_ff;
         best_w_ff    <= cl_w_ff;
         best_h_ff    <= cl_h_ff;
         best_cnt_ff  <= cl_cnt_ff;
         best_area_ff <= area_ff;
      end
   end

   // result register
   logic rsp_valid_ff;
   logic [CMP_W-1:0] out_cnt;

   assign out_cnt = CMP_W'(best_cnt_ff);

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.emit)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found        <= found_ff;
         rsp_group_x      <= best_x_ff;
         rsp_group_y      <= best_y_ff;
         rsp_group_width  <= best_w_ff;
         rsp_group_height <= best_h_ff;
         rsp_member_count <= out_cnt[6:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      status.seed_done    = (seed_ff == n_ff);
      status.seed_visited = visited_ff[seed_ff[IDX_W-1:0]];
      status.stack_empty  = (sp_ff == '0);
      status.pipe_busy    = vld0_ff || vld1_ff || vld2_ff;
      status.scan_last    = (scan_ff == (n_ff - CNT_W'(1)));
      status.out_full     = rsp_valid_ff && !rsp_ready;
   end

endmodule

// File: hdl/best_proximity_cluster_select_top.sv
`timescale 1ns / 1ps
// Loading: one beat per cycle while not evaluating; an item without last_object is taken at once.
// After the closing beat each unvisited seed opens a cluster; one link test per cycle over all stored
// boxes for each member, through a 3-stage test pipe.
// The result sits in an output register; loading of the next frame proceeds while it waits.
// Reset is synchronous, active high: clears control, store count, marks; config to 2 and 1600.
module best_proximity_cluster_select_top #(
   parameter int MAX_OBJECTS = bpcs_pkg::MAX_OBJECTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_addr,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [14:0]        req_box_width,
   input  logic [14:0]        req_box_height,
   input  logic               req_visible,
   input  logic               req_last_object,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic signed [15:0] rsp_group_x,
   output logic signed [15:0] rsp_group_y,
   output logic [16:0]        rsp_group_width,
   output logic [16:0]        rsp_group_height,
   output logic [6:0]         rsp_member_count
);

   bpcs_pkg::cmd_type    cmd;
   bpcs_pkg::status_type status;

   bpcs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_object (req_last_object),
      .req_ready       (req_ready),
      .status          (status),
      .cmd             (cmd)
   );

   bpcs_dpath #(.MAX_OBJECTS(MAX_OBJECTS)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_visible      (req_visible),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_group_x      (rsp_group_x),
      .rsp_group_y      (rsp_group_y),
      .rsp_group_width  (rsp_group_width),
      .rsp_group_height (rsp_group_height),
      .rsp_member_count (rsp_member_count)
   );

   // closing beat stops loading until the result is written to the output register
   a_close_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_object |=> !req_ready)
      else $error("loading continued after closing beat");

   // a result is only written into a free output slot
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_full)
      else $error("result overwrote a pending beat");

   // not found means an all-zero result
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_member_count == '0 && rsp_group_width == '0 &&
      rsp_group_height == '0)
      else $error("not-found result carries data");

   // a found cluster has members
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_member_count != '0)
      else $error("found result with no members");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int OBJ_CAP    = 64;
   localparam int IDLE_LIMIT = 20000;
   localparam int ITEM_GOAL  = 400;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } box_type;

   typedef struct {
      bit                 found;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic [16:0]        gw;
      logic [16:0]        gh;
      logic [6:0]         cnt;
   } group_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
      bit                 vis;
      bit                 last;
      bit                 typed;
      group_type          grp;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic               csr_addr = bpcs_pkg::REG_MIN_PEOPLE;
   logic [15:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [14:0]        req_box_width = '0;
   logic [14:0]        req_box_height = '0;
   logic               req_visible = 1'b0;
   logic               req_last_object = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic signed [15:0] rsp_group_x;
   logic signed [15:0] rsp_group_y;
   logic [16:0]        rsp_group_width;
   logic [16:0]        rsp_group_height;
   logic [6:0]         rsp_member_count;

   // predictor state
   box_type    frame_boxes [OBJ_CAP];
   int         frame_len = 0;
   int         need_members = 2;
   int         link_dist = 1600;
   group_type  group_q [$];
   bit         cur_typed = 0;
   group_type  cur_group;
   int         fail_count = 0;
   int         items_sent = 0;
   int         groups_seen = 0;
   int         found_seen = 0;
   int         idle_cycles = 0;
   bit         quiet = 0;

   best_proximity_cluster_select_top u_top (.*);

   always #5 clock = ~clock;

   function automatic bit boxes_linked(box_type a, box_type b);
      longint dx;
      longint dy;
      longint lim;
      dx = (2 * longint'(a.x) + a.w) - (2 * longint'(b.x) + b.w);
      dy = (2 * longint'(a.y) + a.h) - (2 * longint'(b.y) + b.h);
      lim = 4 * longint'(link_dist) * longint'(link_dist);
      return (dx * dx + dy * dy) < lim;
   endfunction

   // union of two boxes; empty boxes add nothing
   function automatic box_type box_union(box_type a, box_type b);
      box_type r;
      int      x1;
      int      y1;
      if (a.w == 0 || a.h == 0) return b;
      if (b.w == 0 || b.h == 0) return a;
      r.x = (a.x < b.x) ? a.x : b.x;
      r.y = (a.y < b.y) ? a.y : b.y;
      x1 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
      y1 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
      r.w = x1 - r.x;
      r.h = y1 - r.y;
      return r;
   endfunction

   // depth-first cluster walk over the stored boxes, best cluster wins
   function automatic group_type best_cluster();
      group_type g;
      bit        seen [OBJ_CAP];
      int        stack [OBJ_CAP];
      int        sp;
      int        cnt;
      int        u;
      int        need;
      box_type   bx;
      box_type   best;
      int        best_cnt;
      longint    best_area;
      longint    area;
      need = (need_members < 1) ? 1 : need_members;
      best_cnt = 0;
      best_area = 0;
      best = '{0, 0, 0, 0};
      g = '{0, 0, 0, 0, 0, 0};
      foreach (seen[i]) seen[i] = 0;
      for (int seed = 0; seed < frame_len; seed++) begin
         if (seen[seed]) continue;
         seen[seed] = 1;
         stack[0] = seed;
         sp = 1;
         bx = frame_boxes[seed];
         cnt = 0;
         while (sp > 0) begin
            sp = sp - 1;
            u = stack[sp];
            cnt++;
            bx = box_union(bx, frame_boxes[u]);
            for (int i = 0; i < frame_len; i++) begin
               if (!seen[i] && boxes_linked(frame_boxes[u], frame_boxes[i])) begin
                  seen[i] = 1;
                  stack[sp] = i;
                  sp = sp + 1;
               end
            end
         end
         if (cnt >= need) begin
            area = longint'(bx.w) * bx.h;
            if (!g.found || cnt > best_cnt || (cnt == best_cnt && area > best_area)) begin
               best = bx;
               best_cnt = cnt;
               best_area = area;
               g.found = 1;
            end
         end
      end
      if (g.found) begin
         g.gx = best.x[15:0];
         g.gy = best.y[15:0];
         g.gw = best.w[16:0];
         g.gh = best.h[16:0];
         g.cnt = best_cnt[6:0];
      end
      return g;
   endfunction

   // predictor update on an accepted input beat
   task automatic take_object();
      group_type g;
      if (req_visible && frame_len < OBJ_CAP) begin
         frame_boxes[frame_len] = '{int'(req_pos_x), int'(req_pos_y),
                                    int'(req_box_width), int'(req_box_height)};
         frame_len++;
      end
      if (req_last_object) begin
         g = best_cluster();
         frame_len = 0;
         group_q = {group_q, (cur_typed ? cur_group : g)};
      end
   endtask

   task automatic check_group();
      group_type e;
      groups_seen++;
      if (rsp_found) found_seen++;
      if (group_q.size() == 0) begin
         $error("result beat with no expectation pending");
         fail_count++;
         return;
      end
      e = group_q.pop_front();
      if (rsp_found !== e.found) begin
         $error("found: expected %0d actual %0d", e.found, rsp_found);
         fail_count++;
      end
      if (rsp_group_x !== e.gx) begin
         $error("group_x: expected %0d actual %0d", e.gx, rsp_group_x);
         fail_count++;
      end
      if (rsp_group_y !== e.gy) begin
         $error("group_y: expected %0d actual %0d", e.gy, rsp_group_y);
         fail_count++;
      end
      if (rsp_group_width !== e.gw) begin
         $error("group_width: expected %0d actual %0d", e.gw, rsp_group_width);
         fail_count++;
      end
      if (rsp_group_height !== e.gh) begin
         $error("group_height: expected %0d actual %0d", e.gh, rsp_group_height);
         fail_count++;
      end
      if (rsp_member_count !== e.cnt) begin
         $error("member_count: expected %0d actual %0d", e.cnt, rsp_member_count);
         fail_count++;
      end
   endtask

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) take_object();
         if (rsp_valid && rsp_ready) check_group();
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side back-pressure in bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // drives one beat from a falling edge, after an optional random gap; returns at its accepting edge
   task automatic send_beat(row_type r);
      int n;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pos_x       <= r.x;
      req_pos_y       <= r.y;
      req_box_width   <= r.w;
      req_box_height  <= r.h;
      req_visible     <= r.vis;
      req_last_object <= r.last;
      cur_typed = r.typed;
      cur_group = r.grp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(logic addr, logic [15:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (group_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      if (addr == bpcs_pkg::REG_MIN_PEOPLE) need_members = data[6:0];
      else link_dist = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one random frame: clustered boxes around a few anchors, some noise
   task automatic send_frame(int count);
      row_type r;
      int      ax [3];
      int      ay [3];
      int      k;
      int      spread;
      spread = (link_dist < 16) ? 16 : ((link_dist > 8000) ? 8000 : link_dist);
      foreach (ax[i]) begin
         ax[i] = $urandom_range(0, 50000) - 25000;
         ay[i] = $urandom_range(0, 50000) - 25000;
      end
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) begin
            r.x = 16'($urandom);
            r.y = 16'($urandom);
            r.w = 15'($urandom);
            r.h = 15'($urandom);
         end else begin
            r.x = 16'(ax[k] + $urandom_range(0, 2 * spread) - spread);
            r.y = 16'(ay[k] + $urandom_range(0, 2 * spread) - spread);
            r.w = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 2000));
            r.h = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 2000));
         end
         r.vis = ($urandom_range(0, 7) != 0);
         r.last = (i == count - 1);
         r.typed = 0;
         send_beat(r);
      end
   endtask

   row_type dir_tab [12];

   initial begin
      int phase_goal;
      int n;
      dir_tab = '{
         // empty frame: invisible closing beat
         '{0, 0, 0, 0, 0, 1, 1, '{0, 0, 0, 0, 0, 0}},
         // single box is below the default minimum of two
         '{5, 5, 16, 16, 1, 1, 1, '{0, 0, 0, 0, 0, 0}},
         '{0, 0, 16, 16, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{8, 8, 16, 16, 1, 1, 1, '{1, 0, 0, 24, 24, 2}},
         // coordinate extremes, too far apart to link
         '{-32768, -32768, 32767, 32767, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{32767, 32767, 32767, 32767, 1, 1, 1, '{0, 0, 0, 0, 0, 0}},
         // cluster of empty boxes: an empty union takes the last member walked
         '{100, 100, 0, 5, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{110, 100, 7, 0, 1, 1, 1, '{1, 110, 100, 7, 0, 2}},
         // invisible closing beat after a real pair
         '{0, 0, 10, 10, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{20, 0, 10, 10, 1, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{-5, -5, 7, 7, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
         '{-1, 16'sh5555, 15'h2aaa, 15'h5555, 0, 1, 0, '{0, 0, 0, 0, 0, 0}}
      };
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_beat(dir_tab[i]);

      // configuration sweep, extremes included; store-full frames now and then
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'd0);
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'd0);
            end
            1: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'd1);
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'd300);
            end
            2: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'd64);
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'hffff);
            end
            3: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'd3);
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'd2500);
            end
            4: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'($urandom_range(0, 64)));
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'($urandom));
            end
            default: begin
               write_reg(bpcs_pkg::REG_MIN_PEOPLE, 16'd2);
               write_reg(bpcs_pkg::REG_MAX_DIST, 16'd1600);
               quiet = 1;
            end
         endcase
         phase_goal = items_sent + ITEM_GOAL / 6;
         while (items_sent < phase_goal) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                             : $urandom_range(1, 12);
            if (phase == 2 && n < 60 && $urandom_range(0, 1) == 0) n = 64;
            send_frame(n);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (group_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d object beats; %0d frame results checked, %0d with a cluster found,",
               items_sent, groups_seen, found_seen);
      $display("across six register settings including both extremes of each register.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
